### src/swmmm_pkg.sv
package swmmm_pkg;

	// fixed field widths
	localparam int SAMPLE_W = 32;
	localparam int COUNT_W  = 32;
	localparam int SUM_W    = 64;
	localparam int CFG_W    = 7;
	localparam int STEP_W   = $clog2(SUM_W);

	// window size after reset
	localparam logic [CFG_W-1:0] WINDOW_SIZE_RESET = 7'd16;

	// sample counter saturates here
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// result kinds
	localparam logic KIND_WINDOW = 1'b0;
	localparam logic KIND_SERIES = 1'b1;

	// input beat
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last;
	} item_t;

	// result beat
	typedef struct packed {
		logic                       kind;
		logic [COUNT_W-1:0]         window_index;
		logic signed [SAMPLE_W-1:0] max_value;
		logic signed [SAMPLE_W-1:0] min_value;
		logic signed [SAMPLE_W-1:0] mean_value;
		logic                       final_result;
	} result_t;

	// job from front to back: extremes ready, mean still to divide
	typedef struct packed {
		logic                       kind;
		logic [COUNT_W-1:0]         window_index;
		logic signed [SAMPLE_W-1:0] max_value;
		logic signed [SAMPLE_W-1:0] min_value;
		logic signed [SUM_W-1:0]    sum;
		logic [COUNT_W-1:0]         count;
		logic                       final_result;
	} job_t;

endpackage

### src/swmmm_ram.sv
module swmmm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/swmmm_jobq.sv
module swmmm_jobq
	import swmmm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  job_t wr_job,
	output logic full,
	input  logic rd_en,
	output job_t rd_job,
	output logic empty
);

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);

	job_t               mem_q [DEPTH];
	logic [PTR_W-1:0]   wptr_q;
	logic [PTR_W-1:0]   rptr_q;
	logic [PTR_W:0]     cnt_q;
	logic               do_wr;
	logic               do_rd;

	assign full   = (cnt_q == (PTR_W+1)'(DEPTH));
	assign empty  = (cnt_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_job = mem_q[rptr_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(DEPTH-1)) ? '0 : wptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(DEPTH-1)) ? '0 : rptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + (PTR_W+1)'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - (PTR_W+1)'(1);
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wptr_q] <= wr_job;
		end
	end

endmodule

### src/swmmm_front.sv
module swmmm_front
	import swmmm_pkg::*;
#(
	parameter int WINDOW_MAX = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	// input beats
	input  logic             push,
	output logic             full,
	input  item_t            item,
	// configuration
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	// jobs to the back
	output logic             job_wr,
	output job_t             job,
	input  logic             job_full
);

	localparam int AW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int WW   = $clog2(WINDOW_MAX + 1);
	localparam int WS_W = SAMPLE_W + WW;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PUSH_WIN,
		ST_PUSH_SER
	} state_t;

	state_t                     state_q;
	logic [CFG_W-1:0]           window_size_q;
	logic [AW-1:0]              wpos_q;
	logic [COUNT_W-1:0]         count_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SAMPLE_W-1:0] smax_q;
	logic signed [SAMPLE_W-1:0] smin_q;
	logic                       last_q;
	logic [WW-1:0]              w_q;
	logic [COUNT_W-1:0]         index_q;
	logic [AW-1:0]              rd_ptr_q;
	logic [WW-1:0]              issue_cnt_q;
	logic                       rvalid_s1;
	logic                       rfirst_s1;
	logic                       rlast_s1;
	logic signed [SAMPLE_W-1:0] wmax_q;
	logic signed [SAMPLE_W-1:0] wmin_q;
	logic signed [WS_W-1:0]     wsum_q;

	logic                       accept;
	logic signed [SAMPLE_W-1:0] s;
	logic [COUNT_W-1:0]         cfg_ext;
	logic [COUNT_W-1:0]         w_eff32;
	logic [WW-1:0]              w_eff;
	logic [COUNT_W-1:0]         new_count;
	logic                       do_window;
	logic                       issue;
	logic [WW-1:0]              w_m1;
	logic [SAMPLE_W-1:0]        rdata;
	logic signed [SAMPLE_W-1:0] rd_sample;

	assign accept    = push && (state_q == ST_IDLE);
	assign full      = (state_q != ST_IDLE);
	assign s         = item.sample;
	assign rd_sample = rdata;

	// effective window size, clamped to 1..WINDOW_MAX
	always_comb begin
		cfg_ext = {{(COUNT_W-CFG_W){1'b0}}, window_size_q};
		if (cfg_ext == '0) begin
			w_eff32 = COUNT_W'(1);
		end else if (cfg_ext > COUNT_W'(WINDOW_MAX)) begin
			w_eff32 = COUNT_W'(WINDOW_MAX);
		end else begin
			w_eff32 = cfg_ext;
		end
		w_eff = w_eff32[WW-1:0];
	end

	// classify the beat
	assign new_count = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
	assign do_window = (new_count >= {{(COUNT_W-WW){1'b0}}, w_eff});

	// scan read issue
	assign w_m1  = w_q - WW'(1);
	assign issue = (state_q == ST_SCAN) && (issue_cnt_q != w_q);

	swmmm_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (WINDOW_MAX)
	) u_store (
		.clk   (clk),
		.we    (accept),
		.waddr (wpos_q),
		.wdata (s),
		.raddr (rd_ptr_q),
		.rdata (rdata)
	);

	// job to the back
	always_comb begin
		job_wr = 1'b0;
		job    = '0;
		unique case (state_q)
			ST_PUSH_WIN: begin
				job_wr             = 1'b1;
				job.kind           = KIND_WINDOW;
				job.window_index   = index_q;
				job.max_value      = wmax_q;
				job.min_value      = wmin_q;
				job.sum            = {{(SUM_W-WS_W){wsum_q[WS_W-1]}}, wsum_q};
				job.count          = {{(COUNT_W-WW){1'b0}}, w_q};
				job.final_result   = !last_q;
			end
			ST_PUSH_SER: begin
				job_wr             = 1'b1;
				job.kind           = KIND_SERIES;
				job.window_index   = '0;
				job.max_value      = smax_q;
				job.min_value      = smin_q;
				job.sum            = sum_q;
				job.count          = count_q;
				job.final_result   = 1'b1;
			end
			default: begin
				job_wr = 1'b0;
			end
		endcase
	end

	// state machine, series totals and scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			window_size_q <= WINDOW_SIZE_RESET;
			wpos_q        <= '0;
			count_q       <= '0;
			sum_q         <= '0;
			smax_q        <= '0;
			smin_q        <= '0;
			last_q        <= 1'b0;
			w_q           <= '0;
			index_q       <= '0;
			rd_ptr_q      <= '0;
			issue_cnt_q   <= '0;
			rvalid_s1     <= 1'b0;
			rfirst_s1     <= 1'b0;
			rlast_s1      <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_size_q <= cfg_wdata;
			end
			rvalid_s1 <= issue;
			rfirst_s1 <= issue && (issue_cnt_q == '0);
			rlast_s1  <= issue && (issue_cnt_q == w_m1);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						wpos_q <= (wpos_q == AW'(WINDOW_MAX-1)) ? '0 : wpos_q + AW'(1);
						if (count_q == '0) begin
							smax_q <= s;
							smin_q <= s;
						end else begin
							if (s > smax_q) smax_q <= s;
							if (s < smin_q) smin_q <= s;
						end
						if (count_q != COUNT_MAX) begin
							sum_q <= sum_q + {{(SUM_W-SAMPLE_W){s[SAMPLE_W-1]}}, s};
						end
						count_q     <= new_count;
						last_q      <= item.last;
						w_q         <= w_eff;
						index_q     <= new_count - {{(COUNT_W-WW){1'b0}}, w_eff};
						rd_ptr_q    <= wpos_q;
						issue_cnt_q <= '0;
						if (do_window) begin
							state_q <= ST_SCAN;
						end else if (item.last) begin
							state_q <= ST_PUSH_SER;
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						issue_cnt_q <= issue_cnt_q + WW'(1);
						rd_ptr_q    <= (rd_ptr_q == '0) ? AW'(WINDOW_MAX-1)
						                                : rd_ptr_q - AW'(1);
					end
					if (rlast_s1) begin
						state_q <= ST_PUSH_WIN;
					end
				end
				ST_PUSH_WIN: begin
					if (!job_full) begin
						state_q <= last_q ? ST_PUSH_SER : ST_IDLE;
					end
				end
				ST_PUSH_SER: begin
					if (!job_full) begin
						wpos_q  <= '0;
						count_q <= '0;
						sum_q   <= '0;
						smax_q  <= '0;
						smin_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// window max, min and sum over the read beats
	always_ff @(posedge clk) begin
		if (rvalid_s1) begin
			if (rfirst_s1) begin
				wmax_q <= rd_sample;
				wmin_q <= rd_sample;
				wsum_q <= {{WW{rd_sample[SAMPLE_W-1]}}, rd_sample};
			end else begin
				if (rd_sample > wmax_q) wmax_q <= rd_sample;
				if (rd_sample < wmin_q) wmin_q <= rd_sample;
				wsum_q <= wsum_q + {{WW{rd_sample[SAMPLE_W-1]}}, rd_sample};
			end
		end
	end

endmodule

### src/swmmm_back.sv
module swmmm_back
	import swmmm_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	// jobs from the queue
	output logic    job_rd,
	input  job_t    job,
	input  logic    job_empty,
	// result beats
	output logic    empty,
	input  logic    pop,
	output result_t result
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	logic                out_valid_q;
	job_t                job_q;
	logic                neg_q;
	logic [SUM_W-1:0]    dq_q;
	logic [COUNT_W-1:0]  rem_q;
	result_t             out_q;

	logic [COUNT_W:0]    shifted;
	logic                ge;
	logic [COUNT_W:0]    rem_next;
	logic [SUM_W-1:0]    mean_full;
	logic                out_free;
	logic                load_out;

	assign job_rd   = (state_q == ST_IDLE) && !job_empty;
	assign out_free = !out_valid_q || pop;
	assign load_out = (state_q == ST_DONE) && out_free;
	assign empty    = !out_valid_q;
	assign result   = out_q;

	// one restoring division step: remainder shifts in the next dividend bit
	assign shifted   = {rem_q, dq_q[SUM_W-1]};
	assign ge        = (shifted >= {1'b0, job_q.count});
	assign rem_next  = ge ? shifted - {1'b0, job_q.count} : shifted;
	assign mean_full = neg_q ? (~dq_q + SUM_W'(1)) : dq_q;

	// state machine and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!job_empty) begin
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(SUM_W-1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// divider datapath and result register
	always_ff @(posedge clk) begin
		if (job_rd) begin
			job_q <= job;
			neg_q <= job.sum[SUM_W-1];
			dq_q  <= job.sum[SUM_W-1] ? (~job.sum + SUM_W'(1)) : job.sum;
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			dq_q  <= {dq_q[SUM_W-2:0], ge};
			rem_q <= rem_next[COUNT_W-1:0];
		end
		if (load_out) begin
			out_q.kind         <= job_q.kind;
			out_q.window_index <= job_q.window_index;
			out_q.max_value    <= job_q.max_value;
			out_q.min_value    <= job_q.min_value;
			out_q.mean_value   <= mean_full[SAMPLE_W-1:0];
			out_q.final_result <= job_q.final_result;
		end
	end

endmodule

### src/sliding_window_max_min_mean_top.sv
// result path: window scan and job write in the front, then mean division in the back per
// result, before the result beat is loaded into the result register
// input: no new beat is taken until the front has scanned and queued the job of the previous;
// the 64-step shared divider sets the pace; a last beat adds a second division; scan overlaps
// reset: asynchronous, active low; totals and write position cleared, window size 16,
// window store left as is (no clearing pass)
module sliding_window_max_min_mean_top
	import swmmm_pkg::*;
#(
	parameter int WINDOW_MAX = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  item_t            item,
	output logic             empty,
	input  logic             pop,
	output result_t          result,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	logic job_wr;
	logic job_full;
	job_t job_in;
	logic job_rd;
	logic job_empty;
	job_t job_out;

	// scan and classification
	swmmm_front #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.job_wr    (job_wr),
		.job       (job_in),
		.job_full  (job_full)
	);

	// job queue between front and back
	swmmm_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_wr),
		.wr_job (job_in),
		.full   (job_full),
		.rd_en  (job_rd),
		.rd_job (job_out),
		.empty  (job_empty)
	);

	// mean division and result register
	swmmm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_rd    (job_rd),
		.job       (job_out),
		.job_empty (job_empty),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule
